FILE: src/ecev_pkg.sv
// shared widths and curve selector codes for the easing curve evaluator
// no dependencies; imported by the top level
`default_nettype none

package ecev_pkg;

	// field widths at the stream ports
	localparam int T_W       = 20;
	localparam int FUNC_W    = 3;
	localparam int OUT_W     = 17;
	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 24;

	localparam logic [OUT_W-1:0] OUT_MAX = '1;

	// curve selector codes
	localparam logic [FUNC_W-1:0] FN_LINEAR     = 3'd0;
	localparam logic [FUNC_W-1:0] FN_SMOOTH     = 3'd1;
	localparam logic [FUNC_W-1:0] FN_SMOOTHER   = 3'd2;
	localparam logic [FUNC_W-1:0] FN_INQUAD     = 3'd3;
	localparam logic [FUNC_W-1:0] FN_OUTQUAD    = 3'd4;
	localparam logic [FUNC_W-1:0] FN_INOUTQUAD  = 3'd5;
	localparam logic [FUNC_W-1:0] FN_INOUTCUBIC = 3'd6;
	localparam logic [FUNC_W-1:0] FN_OUTBACK    = 3'd7;

endpackage

`default_nettype wire

FILE: src/easing_curve_evaluator_unit.sv
// easing curve evaluator: clamps t to [0,1] and evaluates one of eight curves
// throughput: one beat per cycle while the output is not stalled
// five register stages, three of them end in a multiply
// stalls hold each stage, bubbles between stages are filled in place
// reset clears the stage valid bits only, payload registers are not reset
`default_nettype none

module easing_curve_evaluator_unit
	import ecev_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// input stream
	input  wire logic                 s_axis_tvalid,
	output logic                      s_axis_tready,
	input  wire logic [S_TDATA_W-1:0] s_axis_tdata,  // [19:0] t_in, [23:20] zero
	input  wire logic [FUNC_W-1:0]    s_axis_tuser,  // [2:0] func
	// output stream
	output logic                      m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	output logic      [M_TDATA_W-1:0] m_axis_tdata   // [16:0] eased_value, [23:17] zero
);

	localparam int W    = FRAC_BITS + 1;
	localparam int OPW  = FRAC_BITS + 4;
	localparam int CMPW = (W > T_W) ? W : T_W;
	localparam int RW   = (OPW > OUT_W) ? OPW : OUT_W;

	localparam logic [W-1:0]    ONE_W    = {{(W-1){1'b0}}, 1'b1} << FRAC_BITS;
	localparam logic [W-1:0]    HALF_W   = ONE_W >> 1;
	localparam logic [CMPW-1:0] ONE_CMP  = {{(CMPW-1){1'b0}}, 1'b1} << FRAC_BITS;
	localparam logic [OPW-1:0]  ONE_OP   = {{(OPW-1){1'b0}}, 1'b1} << FRAC_BITS;
	localparam logic [OPW-1:0]  THREE_OP = ONE_OP + (ONE_OP << 1);
	localparam logic [OPW-1:0]  TEN_OP   = (ONE_OP << 3) + (ONE_OP << 1);
	localparam logic [63:0]     C1_FULL  =
		((64'd170158 << FRAC_BITS) + 64'd50000) / 64'd100000;
	localparam logic [OPW-1:0]  C1_OP    = C1_FULL[OPW-1:0];
	localparam logic [OPW-1:0]  C3_OP    = C1_OP + ONE_OP;

	// stage valid bits and per-stage advance
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;

	assign rdy5 = !vld_s5 || m_axis_tready;
	assign rdy4 = !vld_s4 || rdy5;
	assign rdy3 = !vld_s3 || rdy4;
	assign rdy2 = !vld_s2 || rdy3;
	assign rdy1 = !vld_s1 || rdy2;

	assign s_axis_tready = rdy1;
	assign m_axis_tvalid = vld_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (rdy1) vld_s1 <= s_axis_tvalid;
			if (rdy2) vld_s2 <= vld_s1;
			if (rdy3) vld_s3 <= vld_s2;
			if (rdy4) vld_s4 <= vld_s3;
			if (rdy5) vld_s5 <= vld_s4;
		end
	end

	// stage 1: clamp t, form u = 1 - t and the in-out half operand
	logic            t_neg;
	logic [CMPW-1:0] t_raw;
	logic [W-1:0]    t_clamp;
	logic [W-1:0]    u_clamp;
	logic            lo_clamp;

	logic [W-1:0]        t_s1, u_s1, x_s1;
	logic                lo_s1;
	logic [FUNC_W-1:0]   sel_s1;

	assign t_neg    = s_axis_tdata[T_W-1];
	assign t_raw    = CMPW'(s_axis_tdata[T_W-2:0]);
	assign t_clamp  = t_neg ? '0 : ((t_raw > ONE_CMP) ? ONE_W : t_raw[W-1:0]);
	assign u_clamp  = ONE_W - t_clamp;
	assign lo_clamp = t_clamp < HALF_W;

	always_ff @(posedge clk) begin
		if (rdy1) begin
			t_s1   <= t_clamp;
			u_s1   <= u_clamp;
			x_s1   <= lo_clamp ? t_clamp : u_clamp;
			lo_s1  <= lo_clamp;
			sel_s1 <= s_axis_tuser;
		end
	end

	// stage 2: t^2, u^2 and the in-out-quad product 2x*x
	logic [OPW-1:0]    t2_s2, u2_s2, q_s2;
	logic [W-1:0]      t_s2, u_s2, x_s2;
	logic              lo_s2;
	logic [FUNC_W-1:0] sel_s2;

	ecev_mul_rnd #(.FRAC_BITS(FRAC_BITS), .OP_W(OPW)) u_mul_t2 (
		.clk(clk), .en(rdy2), .a(OPW'(t_s1)), .b(OPW'(t_s1)), .p(t2_s2)
	);
	ecev_mul_rnd #(.FRAC_BITS(FRAC_BITS), .OP_W(OPW)) u_mul_u2 (
		.clk(clk), .en(rdy2), .a(OPW'(u_s1)), .b(OPW'(u_s1)), .p(u2_s2)
	);
	ecev_mul_rnd #(.FRAC_BITS(FRAC_BITS), .OP_W(OPW)) u_mul_q (
		.clk(clk), .en(rdy2), .a(OPW'({x_s1, 1'b0})), .b(OPW'(x_s1)), .p(q_s2)
	);

	always_ff @(posedge clk) begin
		if (rdy2) begin
			t_s2   <= t_s1;
			u_s2   <= u_s1;
			x_s2   <= x_s1;
			lo_s2  <= lo_s1;
			sel_s2 <= sel_s1;
		end
	end

	// stage 3: curve-selected product, c1*u^2, smootherstep polynomial,
	// and the curves that are already finished
	logic [OPW-1:0] ma_a, ma_b;
	logic [OPW-1:0] poly_c;
	logic [OPW-1:0] early_c3;

	logic [OPW-1:0]    ma_s3, mb_s3, poly_s3, early_s3;
	logic              lo_s3;
	logic [FUNC_W-1:0] sel_s3;

	always_comb begin
		unique case (sel_s2)
			FN_SMOOTH: begin
				ma_a = t2_s2;
				ma_b = THREE_OP - OPW'({t_s2, 1'b0});
			end
			FN_INOUTCUBIC: begin
				ma_a = lo_s2 ? t2_s2 : u2_s2;
				ma_b = OPW'({x_s2, 2'b00});
			end
			FN_OUTBACK: begin
				ma_a = u2_s2;
				ma_b = OPW'(u_s2);
			end
			default: begin
				ma_a = t2_s2;
				ma_b = OPW'(t_s2);
			end
		endcase
	end

	// 6*t2 + 10 - 15*t, wraps cancel since the result stays in range
	assign poly_c = (t2_s2 << 2) + (t2_s2 << 1) + TEN_OP
	              - ((OPW'(t_s2) << 4) - OPW'(t_s2));

	always_comb begin
		unique case (sel_s2)
			FN_INQUAD:    early_c3 = t2_s2;
			FN_OUTQUAD:   early_c3 = ONE_OP - u2_s2;
			FN_INOUTQUAD: early_c3 = lo_s2 ? q_s2 : (ONE_OP - q_s2);
			default:      early_c3 = OPW'(t_s2);
		endcase
	end

	ecev_mul_rnd #(.FRAC_BITS(FRAC_BITS), .OP_W(OPW)) u_mul_a (
		.clk(clk), .en(rdy3), .a(ma_a), .b(ma_b), .p(ma_s3)
	);
	ecev_mul_rnd #(.FRAC_BITS(FRAC_BITS), .OP_W(OPW)) u_mul_b (
		.clk(clk), .en(rdy3), .a(C1_OP), .b(u2_s2), .p(mb_s3)
	);

	always_ff @(posedge clk) begin
		if (rdy3) begin
			poly_s3  <= poly_c;
			early_s3 <= early_c3;
			lo_s3    <= lo_s2;
			sel_s3   <= sel_s2;
		end
	end

	// stage 4: t^3 * poly or c3 * u^3, out-back positive part
	logic [OPW-1:0] mc_a, mc_b;
	logic [OPW-1:0] early_c4;

	logic [OPW-1:0]    mc_s4, pos_s4, early_s4;
	logic [FUNC_W-1:0] sel_s4;

	always_comb begin
		unique case (sel_s3)
			FN_OUTBACK: begin
				mc_a = C3_OP;
				mc_b = ma_s3;
			end
			default: begin
				mc_a = ma_s3;
				mc_b = poly_s3;
			end
		endcase
	end

	always_comb begin
		unique case (sel_s3)
			FN_SMOOTH:     early_c4 = ma_s3;
			FN_INOUTCUBIC: early_c4 = lo_s3 ? ma_s3 : (ONE_OP - ma_s3);
			default:       early_c4 = early_s3;
		endcase
	end

	ecev_mul_rnd #(.FRAC_BITS(FRAC_BITS), .OP_W(OPW)) u_mul_c (
		.clk(clk), .en(rdy4), .a(mc_a), .b(mc_b), .p(mc_s4)
	);

	always_ff @(posedge clk) begin
		if (rdy4) begin
			pos_s4   <= ONE_OP + mb_s3;
			early_s4 <= early_c4;
			sel_s4   <= sel_s3;
		end
	end

	// stage 5: final pick, out-back floor at zero, saturate to the port width
	logic [OPW-1:0]   fin_c;
	logic [RW-1:0]    fin_ext;
	logic [OUT_W-1:0] res_s5;

	always_comb begin
		unique case (sel_s4)
			FN_SMOOTHER: fin_c = mc_s4;
			FN_OUTBACK:  fin_c = (mc_s4 > pos_s4) ? '0 : (pos_s4 - mc_s4);
			default:     fin_c = early_s4;
		endcase
	end

	assign fin_ext = RW'(fin_c);

	always_ff @(posedge clk) begin
		if (rdy5) begin
			res_s5 <= (fin_ext > RW'(OUT_MAX)) ? OUT_MAX : fin_ext[OUT_W-1:0];
		end
	end

	assign m_axis_tdata = M_TDATA_W'(res_s5);

	// a negative progress value enters stage 1 as zero
	a_clamp_neg: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && s_axis_tdata[T_W-1]) |=> (t_s1 == '0))
		else $error("negative t not clamped to zero");

	// the in-out operand never exceeds one half
	a_half_op: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (x_s1 <= HALF_W && (lo_s1 == (t_s1 < HALF_W))))
		else $error("in-out operand above one half");

	// a taken output with stage 4 empty leaves the output empty
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && !vld_s4) |=> !m_axis_tvalid)
		else $error("output beat repeated");

	// a stalled output keeps stage 4 occupied
	a_hold4: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s4 && m_axis_tvalid && !m_axis_tready) |=> vld_s4)
		else $error("stage 4 item lost under stall");

endmodule

`default_nettype wire

FILE: src/ecev_mul_rnd.sv
// registered fixed-point multiplier with round-to-nearest (ties up)
// standalone; instantiated by easing_curve_evaluator_unit
`default_nettype none

module ecev_mul_rnd #(
	parameter int FRAC_BITS = 16,
	parameter int OP_W      = 20
) (
	input  wire logic            clk,
	input  wire logic            en,
	input  wire logic [OP_W-1:0] a,
	input  wire logic [OP_W-1:0] b,
	output logic      [OP_W-1:0] p
);

	localparam int PW = 2 * OP_W;
	localparam logic [PW-1:0] RND = {{(PW-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);

	logic [PW-1:0] prod;

	// full product plus half an lsb
	assign prod = (PW'(a) * PW'(b)) + RND;

	// drop the fraction bits into the stage register
	always_ff @(posedge clk) begin
		if (en) begin
			p <= prod[FRAC_BITS +: OP_W];
		end
	end

endmodule

`default_nettype wire
